// ===== rtl/core/sti_pkg.sv =====
package sti_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam int OPC_W   = 2;
    localparam int INDEX_W = 5;
    localparam int STEP_W  = 7;
    localparam int SPEED_W = 10;
    localparam int QUERY_W = 11;
    localparam int CFG_W   = 6;
    localparam int ENTRY_W = STEP_W + SPEED_W;
    localparam int KEY_W   = SPEED_W;

    localparam int QUO_W     = 20;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam logic [KEY_W-1:0] MAG_MAX = 10'd1023;

    localparam logic [OPC_W-1:0] OP_WRITE    = 2'd0;
    localparam logic [OPC_W-1:0] OP_TO_STEP  = 2'd1;
    localparam logic [OPC_W-1:0] OP_TO_SPEED = 2'd2;

    typedef struct packed {
        logic             start;
        logic [QUO_W-1:0] dividend;
        logic [KEY_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/core/sti_table.sv =====
module sti_table import sti_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = 5
) (
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [ENTRY_W-1:0] i_wr_data,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [ENTRY_W-1:0] o_rd_data
);

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/sti_div.sv =====
module sti_div import sti_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [KEY_W-1:0]     r_dvs;

    logic [KEY_W:0]       rem_sh;
    logic                 fits;
    logic [KEY_W:0]       rem_diff;
    logic [KEY_W-1:0]     n_rem;
    logic [QUO_W-1:0]     n_quo;

    always_comb begin
        rem_sh   = {r_rem, r_quo[QUO_W-1]};
        fits     = rem_sh >= {1'b0, r_dvs};
        rem_diff = rem_sh - {1'b0, r_dvs};
        n_rem    = fits ? rem_diff[KEY_W-1:0] : rem_sh[KEY_W-1:0];
        n_quo    = {r_quo[QUO_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= i_req.start ? 1'b0
                                  : (r_busy && (r_cnt == DIV_CNT_W'(QUO_W - 1)));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/core/speed_table_interpolator.sv =====
// Converts signed speeds between speed steps and mm/s through a calibration
// table of ascending (speed step, mm/s) pairs held in a single-port-read RAM.
// Input beats carry an opcode: a write beat stores one table entry and gives
// no result, a query beat converts i_query_value and gives one output beat.
// The register entry_count selects how many table entries are in use.
// Write beats never stall the input.
// A query walks the table one entry per cycle, limited by the RAM read port.
// A clamped result comes straight from the table walk; an interpolated one
// also passes through the multiply stage and the restoring divider.
// The input is stalled while a query is in progress, one query at a time.
// The result sits in an output register; the next beat is accepted while it
// waits, but a following query holds its result until the register is free.
// Reset clears the control state and sets entry_count to one. Table entries
// are not cleared and must be written before they are used.
module speed_table_interpolator import sti_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OPC_W-1:0]          i_opcode,
    input  logic [INDEX_W-1:0]        i_entry_index,
    input  logic [STEP_W-1:0]         i_entry_step,
    input  logic [SPEED_W-1:0]        i_entry_speed,
    input  logic signed [QUERY_W-1:0] i_query_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [QUERY_W-1:0] o_converted_value
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_WALK,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_RESULT
    } t_state;

    t_state                     r_state;
    logic [CFG_W-1:0]           r_entry_count;
    logic                       r_by_speed;
    logic                       r_neg;
    logic [KEY_W-1:0]           r_mag;
    logic [AW-1:0]              r_idx;
    logic [AW-1:0]              r_last;
    logic [KEY_W-1:0]           r_k0;
    logic [KEY_W-1:0]           r_v0;
    logic signed [QUERY_W-1:0]  r_diff;
    logic [KEY_W-1:0]           r_off;
    logic [KEY_W-1:0]           r_dk;
    logic signed [QUO_W:0]      r_prod;
    logic                       r_num_neg;
    logic [KEY_W-1:0]           r_res;
    logic                       r_o_valid;
    logic signed [QUERY_W-1:0]  r_o_value;

    logic                       in_accept;
    logic                       is_query;
    logic                       wr_en;
    logic [AW-1:0]              rd_addr;
    logic [ENTRY_W-1:0]         rd_data;
    logic [KEY_W-1:0]           rd_key;
    logic [KEY_W-1:0]           rd_val;
    logic [QUERY_W-1:0]         q_mag;
    logic [KEY_W-1:0]           n_mag;
    logic [AW-1:0]              n_last;
    logic signed [QUO_W+1:0]    mul_full;
    logic signed [QUO_W:0]      num_s;
    logic [QUO_W:0]             num_abs;
    logic signed [QUO_W+1:0]    q_signed;
    logic signed [QUO_W+1:0]    interp_sum;
    logic [KEY_W-1:0]           n_interp;
    logic                       out_free;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign is_query   = (i_opcode == OP_TO_STEP) || (i_opcode == OP_TO_SPEED);
    assign wr_en      = in_accept && (i_opcode == OP_WRITE)
                        && (32'(i_entry_index) < TABLE_DEPTH);
    assign rd_addr    = (r_state == S_IDLE) ? '0 : r_idx + AW'(1);
    assign out_free   = !r_o_valid || !i_out_stall;

    sti_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data ({i_entry_step, i_entry_speed}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (r_by_speed) begin
            rd_key = rd_data[SPEED_W-1:0];
            rd_val = KEY_W'(rd_data[ENTRY_W-1:SPEED_W]);
        end else begin
            rd_key = KEY_W'(rd_data[ENTRY_W-1:SPEED_W]);
            rd_val = rd_data[SPEED_W-1:0];
        end
    end

    always_comb begin
        q_mag = i_query_value[QUERY_W-1] ? QUERY_W'(-i_query_value)
                                         : QUERY_W'(i_query_value);
        n_mag = q_mag[QUERY_W-1] ? MAG_MAX : q_mag[KEY_W-1:0];
    end

    always_comb begin
        if (r_entry_count == '0) begin
            n_last = '0;
        end else if (32'(r_entry_count) > TABLE_DEPTH) begin
            n_last = AW'(TABLE_DEPTH - 1);
        end else begin
            n_last = AW'(r_entry_count - 1'b1);
        end
    end

    always_comb begin
        mul_full = r_diff * $signed({1'b0, r_off});
        num_s    = r_prod + $signed({{(QUO_W - KEY_W + 2){1'b0}}, r_dk[KEY_W-1:1]});
        num_abs  = num_s[QUO_W] ? (QUO_W + 1)'(-num_s) : (QUO_W + 1)'(num_s);
        div_req.start    = (r_state == S_DSTART);
        div_req.dividend = num_abs[QUO_W-1:0];
        div_req.divisor  = r_dk;
    end

    always_comb begin
        q_signed   = $signed({2'b00, div_rsp.quotient});
        interp_sum = $signed({{(QUO_W - KEY_W + 2){1'b0}}, r_v0})
                     + (r_num_neg ? -q_signed : q_signed);
        if (interp_sum < 0) begin
            n_interp = '0;
        end else if (interp_sum > $signed((QUO_W + 2)'(MAG_MAX))) begin
            n_interp = MAG_MAX;
        end else begin
            n_interp = interp_sum[KEY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_out_stall && (r_state != S_RESULT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept && is_query) begin
                        r_by_speed <= (i_opcode == OP_TO_STEP);
                        r_neg      <= i_query_value[QUERY_W-1];
                        r_mag      <= n_mag;
                        r_idx      <= '0;
                        r_last     <= n_last;
                        r_state    <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    r_k0 <= rd_key;
                    r_v0 <= rd_val;
                    if (r_mag <= rd_key || r_idx == r_last) begin
                        r_res   <= rd_val;
                        r_state <= S_RESULT;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_k0 <= r_mag && r_mag <= rd_key) begin
                        if (rd_key == r_k0) begin
                            r_res   <= r_v0;
                            r_state <= S_RESULT;
                        end else begin
                            r_diff  <= $signed({1'b0, rd_val}) - $signed({1'b0, r_v0});
                            r_off   <= r_mag - r_k0;
                            r_dk    <= rd_key - r_k0;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_k0 <= rd_key;
                        r_v0 <= rd_val;
                        if (r_idx == r_last) begin
                            r_res   <= rd_val;
                            r_state <= S_RESULT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_full[QUO_W:0];
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_num_neg <= num_s[QUO_W];
                    r_state   <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        r_res   <= n_interp;
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_value <= r_neg ? -$signed({1'b0, r_res})
                                           : $signed({1'b0, r_res});
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_converted_value = r_o_value;

endmodule

// ===== rtl/core/sti_checker.sv =====
module sti_checker import sti_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic [OPC_W-1:0]          i_opcode,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [QUERY_W-1:0] o_converted_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_converted_value))
        else $error("output beat changed while stalled");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall
        && (i_opcode == OP_TO_STEP || i_opcode == OP_TO_SPEED) |=> o_in_stall)
        else $error("input not stalled after a query beat");

    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result beat without a query in progress");

endmodule

bind speed_table_interpolator sti_checker u_sti_checker (.*);

// ===== test/tb.sv =====
module tb import sti_pkg::*; ();

    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_GAP    = 64;
    localparam int TAIL_CYCLES = 80;
    localparam int PHASE_ITEMS = 62;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        bit                        is_cfg;
        logic [CFG_W-1:0]          count;
        logic [OPC_W-1:0]          op;
        logic [INDEX_W-1:0]        idx;
        logic [STEP_W-1:0]         step;
        logic [SPEED_W-1:0]        speed;
        logic signed [QUERY_W-1:0] q;
        bit                        typed;
        logic signed [QUERY_W-1:0] want;
    } t_plan_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_W-1:0]          i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [OPC_W-1:0]          i_opcode;
    logic [INDEX_W-1:0]        i_entry_index;
    logic [STEP_W-1:0]         i_entry_step;
    logic [SPEED_W-1:0]        i_entry_speed;
    logic signed [QUERY_W-1:0] i_query_value;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [QUERY_W-1:0] o_converted_value;

    logic [STEP_W-1:0]         cal_step [TABLE_DEPTH_DEF];
    logic [SPEED_W-1:0]        cal_speed [TABLE_DEPTH_DEF];
    logic [CFG_W-1:0]          count_setting = CFG_W'(1);
    logic signed [QUERY_W-1:0] pending_conv [$];
    logic signed [QUERY_W-1:0] exp_conv;
    t_plan_row                 plan [$];
    int                        phase_counts [10] = '{32, 2, 31, 33, 16, 5, 1, 63, 0, 24};
    int                        burst_left = 0;
    int                        results_seen = 0;
    int                        fails = 0;
    int                        cycle_cnt = 0;

    speed_table_interpolator u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_entry_index     (i_entry_index),
        .i_entry_step      (i_entry_step),
        .i_entry_speed     (i_entry_speed),
        .i_query_value     (i_query_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_converted_value (o_converted_value)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [QUERY_W-1:0] predict_conversion(
        input logic [OPC_W-1:0] op, input logic signed [QUERY_W-1:0] q);
        bit by_speed;
        bit neg;
        int n;
        int mag;
        int res;
        int k0;
        int k1;
        int v0;
        int v1;
        by_speed = (op == OP_TO_STEP);
        neg = q[QUERY_W-1];
        mag = neg ? -int'(q) : int'(q);
        if (mag > int'(MAG_MAX))
            mag = int'(MAG_MAX);
        n = int'(count_setting);
        if (n == 0)
            n = 1;
        if (n > TABLE_DEPTH_DEF)
            n = TABLE_DEPTH_DEF;
        k0 = by_speed ? int'(cal_speed[0]) : int'(cal_step[0]);
        if (mag <= k0) begin
            res = by_speed ? int'(cal_step[0]) : int'(cal_speed[0]);
        end else begin
            res = by_speed ? int'(cal_step[n-1]) : int'(cal_speed[n-1]);
            for (int i = 0; i + 1 < n; i++) begin
                k0 = by_speed ? int'(cal_speed[i]) : int'(cal_step[i]);
                k1 = by_speed ? int'(cal_speed[i+1]) : int'(cal_step[i+1]);
                if (k0 <= mag && mag <= k1) begin
                    v0 = by_speed ? int'(cal_step[i]) : int'(cal_speed[i]);
                    v1 = by_speed ? int'(cal_step[i+1]) : int'(cal_speed[i+1]);
                    if (k1 == k0)
                        res = v0;
                    else
                        res = v0 + ((v1 - v0) * (mag - k0) + (k1 - k0) / 2) / (k1 - k0);
                    if (res < 0)
                        res = 0;
                    if (res > int'(MAG_MAX))
                        res = int'(MAG_MAX);
                    break;
                end
            end
        end
        return neg ? QUERY_W'(-res) : QUERY_W'(res);
    endfunction

    task automatic send_beat(input logic [OPC_W-1:0] op, input logic [INDEX_W-1:0] idx,
                             input logic [STEP_W-1:0] step, input logic [SPEED_W-1:0] speed,
                             input logic signed [QUERY_W-1:0] q, input bit typed,
                             input logic signed [QUERY_W-1:0] want);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 9);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_opcode      = op;
        i_entry_index = idx;
        i_entry_step  = step;
        i_entry_speed = speed;
        i_query_value = q;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        case (op)
            OP_WRITE: begin
                cal_step[idx]  = step;
                cal_speed[idx] = speed;
            end
            OP_TO_STEP, OP_TO_SPEED: begin
                pending_conv.push_back(typed ? want : predict_conversion(op, q));
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_entry_count(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_conv.size() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        count_setting = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = CFG_W'($urandom_range(0, 63));
    endtask

    task automatic load_table(input bit randomized);
        logic [STEP_W-1:0]  steps [$];
        logic [SPEED_W-1:0] speeds [$];
        for (int i = 0; i < TABLE_DEPTH_DEF; i++) begin
            steps.push_back(randomized ? STEP_W'($urandom_range(0, 127)) : STEP_W'(3 + 4 * i));
            speeds.push_back(randomized ? SPEED_W'($urandom_range(0, 1023))
                                        : SPEED_W'(31 + 32 * i));
        end
        steps.sort();
        speeds.sort();
        for (int i = 0; i < TABLE_DEPTH_DEF; i++)
            send_beat(OP_WRITE, INDEX_W'(i), steps[i], speeds[i],
                      QUERY_W'($urandom_range(0, 2047)), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_conv.size() == 0) begin
                $error("converted_value: expected none, actual %0d", o_converted_value);
                fails++;
            end else begin
                exp_conv = pending_conv.pop_front();
                if (o_converted_value !== exp_conv) begin
                    $error("converted_value: expected %0d, actual %0d",
                           exp_conv, o_converted_value);
                    fails++;
                end
            end
        end
    end

    // The receiver stalls in segments of changing character, and once holds off
    // for a long stretch so that the block backs up into its input.
    initial begin
        int  seg;
        int  mode;
        bit  held;
        i_out_stall = 1'b0;
        held = 1'b0;
        forever begin
            if (!held && results_seen >= 150) begin
                held = 1'b1;
                @(negedge i_clk);
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            seg  = $urandom_range(20, 120);
            mode = $urandom_range(0, 3);
            for (int k = 0; k < seg; k++) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_stall = 1'b0;
                    1: i_out_stall = 1'($urandom_range(0, 1));
                    2: i_out_stall = ($urandom_range(0, 3) != 0);
                    default: i_out_stall = k[1];
                endcase
            end
        end
    end

    initial begin
        int                        pick;
        int                        widx;
        int                        lo;
        int                        hi;
        int                        mag;
        int                        done_items;
        logic [OPC_W-1:0]          op;
        logic [STEP_W-1:0]         step;
        logic [SPEED_W-1:0]        speed;
        logic signed [QUERY_W-1:0] q;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_WRITE;
        i_entry_index = '0;
        i_entry_step  = '0;
        i_entry_speed = '0;
        i_query_value = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        load_table(1'b0);

        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, 11'sd0, 1'b1, 11'sd31});
        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, 11'sh400, 1'b1, -11'sd31});
        plan.push_back('{1'b0, 6'd0, OP_TO_STEP, 5'd0, 7'd0, 10'd0, 11'sd1023, 1'b1, 11'sd3});
        plan.push_back('{1'b0, 6'd0, OP_TO_STEP, 5'd0, 7'd0, 10'd0, -11'sd1, 1'b1, -11'sd3});
        plan.push_back('{1'b0, 6'd0, OP_UNUSED, 5'd31, 7'd127, 10'd1023, 11'sd77, 1'b0, 11'sd0});
        plan.push_back('{1'b1, 6'd0, OP_WRITE, 5'd0, 7'd0, 10'd0, 11'sd0, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, 11'sd1023, 1'b1, 11'sd31});
        plan.push_back('{1'b1, 6'd63, OP_WRITE, 5'd0, 7'd0, 10'd0, 11'sd0, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, 11'sd1023, 1'b1, 11'sd1023});
        plan.push_back('{1'b0, 6'd0, OP_TO_STEP, 5'd0, 7'd0, 10'd0, -11'sd1023, 1'b1, -11'sd127});
        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, 11'sd5, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_STEP, 5'd0, 7'd0, 10'd0, -11'sd50, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, -11'sd127, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_STEP, 5'd0, 7'd0, 10'd0, 11'sd0, 1'b1, 11'sd3});
        plan.push_back('{1'b0, 6'd0, OP_WRITE, 5'd2, 7'd7, 10'd900, 11'sd0, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, 11'sd7, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, 11'sd10, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, -11'sd10, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_STEP, 5'd0, 7'd0, 10'd0, 11'sd600, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_WRITE, 5'd0, 7'd0, 10'd0, 11'sd0, 1'b0, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_STEP, 5'd0, 7'd0, 10'd0, 11'sd0, 1'b1, 11'sd0});
        plan.push_back('{1'b0, 6'd0, OP_TO_SPEED, 5'd0, 7'd0, 10'd0, 11'sh400, 1'b1, -11'sd1023});
        plan.push_back('{1'b0, 6'd0, OP_TO_STEP, 5'd0, 7'd0, 10'd0, 11'sh400, 1'b0, 11'sd0});

        foreach (plan[r]) begin
            if (plan[r].is_cfg)
                set_entry_count(plan[r].count);
            else
                send_beat(plan[r].op, plan[r].idx, plan[r].step, plan[r].speed,
                          plan[r].q, plan[r].typed, plan[r].want);
        end

        foreach (phase_counts[p]) begin
            set_entry_count(CFG_W'(phase_counts[p]));
            if ($urandom_range(0, 1) == 1)
                load_table(1'b1);
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                pick  = $urandom_range(0, 99);
                widx  = $urandom_range(0, TABLE_DEPTH_DEF - 1);
                step  = STEP_W'($urandom_range(0, 127));
                speed = SPEED_W'($urandom_range(0, 1023));
                q     = QUERY_W'($urandom_range(0, 2047));
                if (pick < 4) begin
                    send_beat(OP_UNUSED, INDEX_W'(widx), step, speed, q, 1'b0, '0);
                end else if (pick < 22) begin
                    done_items++;
                    // Most writes keep the table ascending around the written entry.
                    if ($urandom_range(0, 3) != 0) begin
                        lo = (widx == 0) ? 0 : int'(cal_step[widx-1]);
                        hi = (widx == TABLE_DEPTH_DEF - 1) ? 127 : int'(cal_step[widx+1]);
                        if (lo <= hi)
                            step = STEP_W'($urandom_range(lo, hi));
                        lo = (widx == 0) ? 0 : int'(cal_speed[widx-1]);
                        hi = (widx == TABLE_DEPTH_DEF - 1) ? 1023 : int'(cal_speed[widx+1]);
                        if (lo <= hi)
                            speed = SPEED_W'($urandom_range(lo, hi));
                    end
                    send_beat(OP_WRITE, INDEX_W'(widx), step, speed, q, 1'b0, '0);
                end else begin
                    done_items++;
                    op = (pick < 61) ? OP_TO_STEP : OP_TO_SPEED;
                    if (op == OP_TO_SPEED && $urandom_range(0, 9) < 7)
                        mag = $urandom_range(0, 130);
                    else
                        mag = $urandom_range(0, 1023);
                    q = QUERY_W'(($urandom_range(0, 1) == 1) ? -mag : mag);
                    if ($urandom_range(0, 24) == 0)
                        q = 11'sh400;
                    send_beat(op, INDEX_W'(widx), step, speed, q, 1'b0, '0);
                end
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_conv.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
